### hdl/plen_pkg.sv
// Shared widths and parameter defaults for the polyline length accumulator.
`default_nettype none
package plen_pkg;

  // Fixed port widths
  localparam int unsigned XY_W      = 31;
  localparam int unsigned LEN_OUT_W = 48;
  localparam int unsigned IDX_OUT_W = 8;

  // Parameter defaults
  localparam int unsigned MAX_SEGMENTS_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 31;
  localparam int unsigned LENGTH_BITS_DEF  = 48;

endpackage
`default_nettype wire

### hdl/polyline_length_accumulator.sv
// Top level: polyline length accumulator with serial squaring and square root.
//
// Usage: points enter on the input channel (in_valid/in_stall) with x, y and
// the seg_end/path_end marks; path_end also ends the segment. Each segment end
// yields one word on the output channel (out_valid/out_stall) carrying the
// segment length, running path length, segment index, longest segment so far
// and path_done. Points that do not end a segment yield nothing.
// Order of work: a point that opens a segment goes straight to the report step.
// Any later point passes through COORD_BITS squarer steps, one hand-off,
// COORD_BITS + 1 root steps, one hand-off, one accumulate, one report and one
// idle step before the next point is taken. One point is in flight at a
// time; in_stall is high while it is worked on.
// Reset (rst, synchronous) clears all path state and empties the output.
// A result waits in the output register while out_stall is high; the next
// point is still taken and worked on, and only its own report waits for the
// output register to drain.
`default_nettype none
module polyline_length_accumulator #(
  parameter int unsigned MAX_SEGMENTS = plen_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = plen_pkg::COORD_BITS_DEF,
  parameter int unsigned LENGTH_BITS  = plen_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [plen_pkg::XY_W-1:0]    x,
  input  wire logic signed [plen_pkg::XY_W-1:0]    y,
  input  wire logic                                seg_end,
  input  wire logic                                path_end,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [plen_pkg::LEN_OUT_W-1:0]           seg_length,
  output logic [plen_pkg::LEN_OUT_W-1:0]           path_length,
  output logic [plen_pkg::IDX_OUT_W-1:0]           seg_number,
  output logic [plen_pkg::IDX_OUT_W-1:0]           longest_index,
  output logic [plen_pkg::LEN_OUT_W-1:0]           longest_length,
  output logic                                     path_done
);
  import plen_pkg::*;

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned SQ_W   = 2 * CB + 1;
  localparam int unsigned RAD_W  = 2 * CB + 2;
  localparam int unsigned ROOT_W = CB + 1;
  localparam int unsigned LB     = LENGTH_BITS;
  localparam int unsigned SEG_W  = $clog2(MAX_SEGMENTS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                 state;
  logic signed [CB-1:0]   prev_x;
  logic signed [CB-1:0]   prev_y;
  logic                   have_prev;
  logic                   send_r;
  logic                   pend_r;
  logic [LB-1:0]          seg_total;
  logic [LB-1:0]          path_total;
  logic [LB-1:0]          best_length;
  logic [SEG_W-1:0]       best_index;
  logic [SEG_W-1:0]       seg_counter;

  logic                   accept;
  logic signed [CB-1:0]   xs;
  logic signed [CB-1:0]   ys;
  logic [CB:0]            dxa, dxb, dya, dyb;
  logic [CB-1:0]          dx, dy;
  logic                   sq_done;
  logic [SQ_W-1:0]        sq_sum;
  logic                   rt_start;
  logic                   rt_done;
  logic [ROOT_W-1:0]      rt_root;
  logic [LB:0]            seg_sum;
  logic [LB-1:0]          seg_total_next;
  logic [LB:0]            path_sum;
  logic [LB-1:0]          path_total_next;
  logic                   better;
  logic                   report;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Coordinates taken from their low COORD_BITS, sign-extended
  assign xs = x[CB-1:0];
  assign ys = y[CB-1:0];

  // Absolute differences: both subtractions in parallel, pick by sign
  always_comb begin
    dxa = {xs[CB-1], xs} - {prev_x[CB-1], prev_x};
    dxb = {prev_x[CB-1], prev_x} - {xs[CB-1], xs};
    dya = {ys[CB-1], ys} - {prev_y[CB-1], prev_y};
    dyb = {prev_y[CB-1], prev_y} - {ys[CB-1], ys};
    dx  = dxa[CB] ? dxb[CB-1:0] : dxa[CB-1:0];
    dy  = dya[CB] ? dyb[CB-1:0] : dya[CB-1:0];
  end

  plen_sumsq #(
    .COORD_BITS(COORD_BITS)
  ) u_sumsq (
    .clk  (clk),
    .rst  (rst),
    .start(accept && have_prev),
    .dx   (dx),
    .dy   (dy),
    .done (sq_done),
    .sum  (sq_sum)
  );

  assign rt_start = (state == ST_MUL) && sq_done;

  plen_isqrt #(
    .COORD_BITS(COORD_BITS)
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (rt_start),
    .radicand(RAD_W'(sq_sum)),
    .done    (rt_done),
    .root    (rt_root)
  );

  // Saturating sums and longest compare
  always_comb begin
    seg_sum         = {1'b0, seg_total} + (LB + 1)'(rt_root);
    seg_total_next  = seg_sum[LB] ? '1 : seg_sum[LB-1:0];
    path_sum        = {1'b0, path_total} + {1'b0, seg_total};
    path_total_next = path_sum[LB] ? '1 : path_sum[LB-1:0];
    better          = (seg_total > best_length);
    report          = (state == ST_FIN) && send_r && (!out_valid || !out_stall);
  end

  // Control and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev_x      <= '0;
      prev_y      <= '0;
      have_prev   <= 1'b0;
      send_r      <= 1'b0;
      pend_r      <= 1'b0;
      seg_total   <= '0;
      path_total  <= '0;
      best_length <= '0;
      best_index  <= '0;
      seg_counter <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            prev_x    <= xs;
            prev_y    <= ys;
            have_prev <= 1'b1;
            send_r    <= seg_end || path_end;
            pend_r    <= path_end;
            state     <= have_prev ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          if (sq_done) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (rt_done) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          seg_total <= seg_total_next;
          state     <= ST_FIN;
        end
        ST_FIN: begin
          if (!send_r) begin
            state <= ST_IDLE;
          end else if (report) begin
            state <= ST_IDLE;
            if (pend_r) begin
              prev_x      <= '0;
              prev_y      <= '0;
              have_prev   <= 1'b0;
              seg_total   <= '0;
              path_total  <= '0;
              best_length <= '0;
              best_index  <= '0;
              seg_counter <= '0;
            end else begin
              prev_x     <= '0;
              prev_y     <= '0;
              have_prev  <= 1'b0;
              seg_total  <= '0;
              path_total <= path_total_next;
              if (better) begin
                best_length <= seg_total;
                best_index  <= seg_counter;
              end
              if (seg_counter < SEG_W'(MAX_SEGMENTS - 1)) begin
                seg_counter <= seg_counter + SEG_W'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      seg_length     <= LEN_OUT_W'(seg_total);
      path_length    <= LEN_OUT_W'(path_total_next);
      seg_number     <= IDX_OUT_W'(seg_counter);
      longest_index  <= better ? IDX_OUT_W'(seg_counter) : IDX_OUT_W'(best_index);
      longest_length <= better ? LEN_OUT_W'(seg_total) : LEN_OUT_W'(best_length);
      path_done      <= pend_r;
    end
  end

endmodule
`default_nettype wire

### hdl/plen_sumsq.sv
// Bit-serial sum of squares dx*dx + dy*dy, one multiplier bit per cycle (MSB first).
`default_nettype none
module plen_sumsq #(
  parameter int unsigned COORD_BITS = plen_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [COORD_BITS-1:0]   dx,
  input  wire logic [COORD_BITS-1:0]   dy,
  output logic                         done,
  output logic [2*COORD_BITS:0]        sum
);
  import plen_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * CB + 1;
  localparam int unsigned CNT_W = $clog2(CB + 1);

  logic [CB-1:0]    mcx;    // multiplicands, held
  logic [CB-1:0]    mcy;
  logic [CB-1:0]    mx;     // multiplier bits, shifted out MSB first
  logic [CB-1:0]    my;
  logic [SQ_W-1:0]  acc;
  logic [SQ_W-1:0]  acc_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  // Horner step: acc = 2*acc + bit_x*dx + bit_y*dy
  always_comb begin
    acc_next = {acc[SQ_W-2:0], 1'b0}
             + (mx[CB-1] ? SQ_W'(mcx) : '0)
             + (my[CB-1] ? SQ_W'(mcy) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(CB);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      mcx <= dx;
      mcy <= dy;
      mx  <= dx;
      my  <= dy;
      acc <= '0;
    end else if (busy) begin
      mx  <= {mx[CB-2:0], 1'b0};
      my  <= {my[CB-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign sum = acc;

endmodule
`default_nettype wire

### hdl/plen_isqrt.sv
// Bit-serial restoring integer square root, one root bit per cycle.
`default_nettype none
module plen_isqrt #(
  parameter int unsigned COORD_BITS = plen_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [2*COORD_BITS+1:0]   radicand,
  output logic                           done,
  output logic [COORD_BITS:0]            root
);
  import plen_pkg::*;

  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;   // radicand, two bits shifted out per step
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_next;
  logic              ge;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  // One step: bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem_sh   = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial    = {root, 2'b01};
    ge       = (rem_sh >= trial);
    rem_next = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### hdl/plen_checker.sv
// Port-level checker for the polyline length accumulator, bound to the top level.
`default_nettype none
module plen_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [plen_pkg::LEN_OUT_W-1:0]      seg_length,
  input wire logic [plen_pkg::LEN_OUT_W-1:0]      path_length,
  input wire logic [plen_pkg::IDX_OUT_W-1:0]      seg_number,
  input wire logic [plen_pkg::IDX_OUT_W-1:0]      longest_index,
  input wire logic [plen_pkg::LEN_OUT_W-1:0]      longest_length,
  input wire logic                                path_done
);
  import plen_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seg_length)
      && $stable(path_length) && $stable(path_done))
    else $error("stalled output word changed");

  // One point at a time: busy right after a point is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous point still in work");

  // Path total covers the segment just ended
  a_path_covers_seg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seg_length <= path_length)
    else $error("segment length exceeds path length");

  // Path total covers the longest segment
  a_path_covers_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> longest_length <= path_length)
    else $error("longest segment exceeds path length");

  // Longest segment is never a later one
  a_best_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> longest_index <= seg_number)
    else $error("longest index beyond current segment");

endmodule

bind polyline_length_accumulator plen_checker u_plen_checker (.*);
`default_nettype wire

### verif/tb.sv
// Testbench for the polyline length accumulator: directed table plus random paths.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plen_pkg::*;

  typedef logic signed [XY_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   seg_end;
    logic   path_end;
  } point_t;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] seg_len;
    logic [LEN_OUT_W-1:0] path_len;
    logic [IDX_OUT_W-1:0] seg_num;
    logic [IDX_OUT_W-1:0] best_idx;
    logic [LEN_OUT_W-1:0] best_len;
    logic                 done;
  } report_t;

  typedef struct {
    point_t  pt;
    bit      typed;
    report_t want;
  } table_row_t;

  // How a segment picks its coordinates
  typedef enum int unsigned {SPREAD, WALK, CORNER, NEAR_ORIGIN} coord_style_t;

  localparam coord_t COORD_MAX = {1'b0, {(XY_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(XY_W-1){1'b0}}};
  localparam logic [IDX_OUT_W-1:0] LAST_SEG_IDX = IDX_OUT_W'(MAX_SEGMENTS_DEF - 1);
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned LONG_HOLD = 1500;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t x = '0;
  coord_t y = '0;
  logic seg_end = 1'b0;
  logic path_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LEN_OUT_W-1:0] seg_length;
  logic [LEN_OUT_W-1:0] path_length;
  logic [IDX_OUT_W-1:0] seg_number;
  logic [IDX_OUT_W-1:0] longest_index;
  logic [LEN_OUT_W-1:0] longest_length;
  logic path_done;

  polyline_length_accumulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x(x), .y(y), .seg_end(seg_end), .path_end(path_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .seg_length(seg_length), .path_length(path_length), .seg_number(seg_number),
    .longest_index(longest_index), .longest_length(longest_length),
    .path_done(path_done)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Path measurement state mirrored on the testbench side
  coord_t last_x, last_y;
  bit have_last;
  logic [LEN_OUT_W-1:0] seg_sum, path_sum, best_len;
  logic [IDX_OUT_W-1:0] best_idx, seg_idx;

  report_t pending_reports[$];
  table_row_t stimulus_table[$];
  int unsigned points_sent;
  int unsigned mismatches;
  bit sender_quiet;

  function automatic void clear_path_state();
    last_x = '0;
    last_y = '0;
    have_last = 1'b0;
    seg_sum = '0;
    path_sum = '0;
    best_len = '0;
    best_idx = '0;
    seg_idx = '0;
  endfunction

  // Largest r with r*r <= v, one bit at a time from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [LEN_OUT_W-1:0] sat_len(input logic [LEN_OUT_W-1:0] a,
                                                   input logic [LEN_OUT_W-1:0] b);
    logic [LEN_OUT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_OUT_W] ? '1 : s[LEN_OUT_W-1:0];
  endfunction

  // Advance the path state by one point; returns 1 when a segment closes
  function automatic bit measure_point(input point_t p, output report_t r);
    longint dxs, dys;
    longint unsigned dx, dy;
    r = '0;
    if (have_last) begin
      dxs = longint'(p.x) - longint'(last_x);
      dys = longint'(p.y) - longint'(last_y);
      dx = (dxs < 0) ? -dxs : dxs;
      dy = (dys < 0) ? -dys : dys;
      seg_sum = sat_len(seg_sum, LEN_OUT_W'(floor_root(dx * dx + dy * dy)));
    end
    last_x = p.x;
    last_y = p.y;
    have_last = 1'b1;
    if (!(p.seg_end || p.path_end)) return 1'b0;

    path_sum = sat_len(path_sum, seg_sum);
    if (seg_sum > best_len) begin
      best_len = seg_sum;
      best_idx = seg_idx;
    end
    r = {seg_sum, path_sum, seg_idx, best_idx, best_len, p.path_end};
    if (p.path_end) begin
      clear_path_state();
    end else begin
      seg_sum = '0;
      have_last = 1'b0;
      last_x = '0;
      last_y = '0;
      if (seg_idx != LAST_SEG_IDX) seg_idx++;
    end
    return 1'b1;
  endfunction

  function automatic coord_t pick_coord(input coord_style_t style, input coord_t base);
    case (style)
      SPREAD: return coord_t'($urandom());
      WALK: return base + coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
      CORNER: begin
        case ($urandom_range(0, 3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'($urandom_range(0, 200)) - coord_t'(100);
    endcase
  endfunction

  task automatic table_row(input int xv, input int yv, input bit se, input bit pe,
                           input bit typed, input report_t want);
    table_row_t row;
    row.pt = {coord_t'(xv), coord_t'(yv), se, pe};
    row.typed = typed;
    row.want = want;
    stimulus_table = {stimulus_table, row};
  endtask

  // Offer one point, wait for it to be taken, then record what it should report
  task automatic send_point(input point_t p, input bit typed, input report_t want);
    report_t predicted;
    int unsigned gap;
    if (points_sent % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x <= p.x;
    y <= p.y;
    seg_end <= p.seg_end;
    path_end <= p.path_end;
    do @(posedge clk); while (in_stall);
    if (measure_point(p, predicted))
      pending_reports = {pending_reports, (typed ? want : predicted)};
    points_sent++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Stimulus
  initial begin
    int unsigned nseg, npts;
    coord_style_t style;
    point_t p;
    bit long_done;

    clear_path_state();
    points_sent = 0;
    mismatches = 0;
    long_done = 1'b0;
    p = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table: single point after reset, 3-4-5, extremes, ties, boundaries
    table_row(0, 0, 1, 0, 1, {48'd0, 48'd0, 8'd0, 8'd0, 48'd0, 1'b0});
    table_row(0, 0, 0, 0, 0, '0);
    table_row(3, 4, 1, 0, 1, {48'd5, 48'd5, 8'd1, 8'd1, 48'd5, 1'b0});
    table_row(-1073741824, -1073741824, 0, 0, 0, '0);
    table_row(1073741823, 1073741823, 0, 1, 0, '0);       // path end alone
    table_row(0, 0, 0, 0, 0, '0);
    table_row(0, 5, 1, 0, 1, {48'd5, 48'd5, 8'd0, 8'd0, 48'd5, 1'b0});
    table_row(10, 0, 0, 0, 0, '0);
    table_row(10, 5, 1, 0, 1, {48'd5, 48'd10, 8'd1, 8'd0, 48'd5, 1'b0}); // tie
    table_row(0, 0, 0, 0, 0, '0);
    table_row(1, 1, 0, 0, 0, '0);
    table_row(2, 2, 1, 0, 0, '0);
    table_row(7, 7, 1, 1, 1, {48'd0, 48'd12, 8'd3, 8'd0, 48'd5, 1'b1});
    table_row(1073741823, -1073741824, 0, 0, 0, '0);
    table_row(-1073741824, 1073741823, 1, 1, 0, '0);
    table_row(100, 0, 1, 0, 1, {48'd0, 48'd0, 8'd0, 8'd0, 48'd0, 1'b0});
    table_row(0, 0, 0, 0, 0, '0);                           // no link to prior segment
    table_row(0, 0, 1, 1, 1, {48'd0, 48'd0, 8'd1, 8'd0, 48'd0, 1'b1});
    foreach (stimulus_table[i])
      send_point(stimulus_table[i].pt, stimulus_table[i].typed, stimulus_table[i].want);

    // Random paths, some noise, and one path long enough to pin the segment index
    while (points_sent < ITEM_TARGET) begin
      if (!long_done && points_sent > 800) begin
        long_done = 1'b1;
        for (int s = 0; s < 280; s++) begin
          npts = (s == 279 || $urandom_range(0, 7) == 0) ? 2 : 1;
          for (int k = 0; k < npts; k++) begin
            if (s == 279) begin
              p.x = (k == 0) ? COORD_MIN : COORD_MAX;
              p.y = (k == 0) ? COORD_MIN : COORD_MAX;
            end else begin
              p.x = pick_coord(SPREAD, p.x);
              p.y = pick_coord(SPREAD, p.y);
            end
            p.seg_end = (k == npts - 1);
            p.path_end = (s == 279) && (k == npts - 1);
            send_point(p, 1'b0, '0);
          end
        end
      end else if ($urandom_range(0, 9) == 0) begin
        npts = $urandom_range(1, 4);
        for (int k = 0; k < npts; k++) begin
          p.x = pick_coord(SPREAD, p.x);
          p.y = pick_coord(SPREAD, p.y);
          p.seg_end = ($urandom_range(0, 3) == 0);
          p.path_end = ($urandom_range(0, 7) == 0);
          send_point(p, 1'b0, '0);
        end
      end else begin
        nseg = $urandom_range(1, 6);
        for (int s = 0; s < nseg; s++) begin
          npts = $urandom_range(1, 5);
          style = coord_style_t'($urandom_range(0, 3));
          for (int k = 0; k < npts; k++) begin
            p.x = pick_coord(style, p.x);
            p.y = pick_coord(style, p.y);
            p.seg_end = (k == npts - 1);
            p.path_end = (s == nseg - 1) && (k == npts - 1);
            if (p.path_end) p.seg_end = $urandom_range(0, 1);
            send_point(p, 1'b0, '0);
          end
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("polyline_length_accumulator: match");
    end else begin
      $display("polyline_length_accumulator: mismatch");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, field-by-field compare
  initial begin
    int unsigned hold, reports_seen;
    bit quiet;
    report_t got, want;
    reports_seen = 0;
    quiet = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (reports_seen % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (reports_seen == 60) hold = LONG_HOLD;
      else hold = quiet ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got = {seg_length, path_length, seg_number, longest_index, longest_length, path_done};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("unexpected word: seg_length %0d seg_number %0d", seg_length, seg_number);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("seg_length", 64'(want.seg_len), 64'(got.seg_len));
        check_field("path_length", 64'(want.path_len), 64'(got.path_len));
        check_field("seg_number", 64'(want.seg_num), 64'(got.seg_num));
        check_field("longest_index", 64'(want.best_idx), 64'(got.best_idx));
        check_field("longest_length", 64'(want.best_len), 64'(got.best_len));
        check_field("path_done", 64'(want.done), 64'(got.done));
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("polyline_length_accumulator: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
